/* rtl/core/cgfsp_pkg.sv */
package cgfsp_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_MAX_ROWS = 256;
  localparam int DEFAULT_MAX_COLS = 256;

  // fixed field widths
  localparam int VALUE_W    = 16;
  localparam int IDX_W      = 8;
  localparam int POS_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_IN_USE      = 2'd0,
    CFG_COLS_IN_USE      = 2'd1,
    CFG_FIRST_ROW_CENTER = 2'd2,
    CFG_ROW_BIN_WIDTH    = 2'd3
  } cfg_index_t;

  // configuration reset values
  localparam logic [8:0]         RESET_ROWS_IN_USE      = 9'd256;
  localparam logic [8:0]         RESET_COLS_IN_USE      = 9'd256;
  localparam logic signed [23:0] RESET_FIRST_ROW_CENTER = 24'sd128;
  localparam logic [15:0]        RESET_ROW_BIN_WIDTH    = 16'd256;

  // one result beat as it sits in the output queue
  typedef struct packed {
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic [VALUE_W-1:0] filled;
    logic [VALUE_W-1:0] smoothed;
    logic               done;
    logic               found;
    logic [IDX_W-1:0]   peak_row;
    logic [POS_W-1:0]   position;
  } res_item_t;

endpackage

/* rtl/core/column_gap_fill_smooth_peak_core.sv */
// column gap fill, 1-2-1 vertical smoothing and per-column peak search
//
// bins stream in on bin_valid/bin_ready, column by column, rows ascending
// within a column. results leave on res_valid/res_ready, one beat per bin,
// lagging the input by two rows; the last bin of a column flushes the last
// two rows, and the final beat carries column_done with the peak fields.
// configuration is written on cfg_valid/cfg_ready (always ready); the user
// must write it only while idle, which the block does not enforce.
//
// a result beat is offered once through the pending stage and the queue.
// throughput: one bin per cycle while bin_ready holds; a column end makes
// three beats, so sustained input rate follows the output side, set by the
// 8-entry queue and the single result port.
// bin_ready is high while the queue plus the pending stage hold at most
// five beats, so a column-end burst of three always fits.
// when the receiver stalls the queue fills and bin_ready drops; nothing
// is lost. reset restores register defaults, clears the row/column
// counters, windows and peak tracker, and empties the queue.
module column_gap_fill_smooth_peak_core #(
  parameter int MAX_ROWS = cgfsp_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = cgfsp_pkg::DEFAULT_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cgfsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cgfsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  // bin input channel
  input  logic                                 bin_valid,
  output logic                                 bin_ready,
  input  logic [cgfsp_pkg::VALUE_W-1:0]        bin_value,
  // result channel
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [cgfsp_pkg::IDX_W-1:0]          out_col,
  output logic [cgfsp_pkg::IDX_W-1:0]          out_row,
  output logic [cgfsp_pkg::VALUE_W-1:0]        filled_value,
  output logic [cgfsp_pkg::VALUE_W-1:0]        smoothed_value,
  output logic                                 column_done,
  output logic                                 peak_found,
  output logic [cgfsp_pkg::IDX_W-1:0]          peak_row,
  output logic signed [cgfsp_pkg::POS_W-1:0]   peak_position
);
  import cgfsp_pkg::*;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RC_W    = $clog2(MAX_ROWS + 1);
  localparam int CC_W    = $clog2(MAX_COLS + 1);
  localparam int RCMP_W  = ((RC_W > 9) ? RC_W : 9) + 1;
  localparam int CCMP_W  = ((CC_W > 9) ? CC_W : 9) + 1;
  localparam int PROD_W  = ROW_W + 16;
  // one bit for the carry of centre plus product, one for the sign
  localparam int SUM_W   = ((PROD_W > 24) ? PROD_W : 24) + 2;
  localparam int DEPTH   = 8;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int BURST   = 3;

  // truncated mean of the two vertical neighbours, only for a zero bin
  function automatic logic [VALUE_W-1:0] gap_fill(input logic [VALUE_W-1:0] centre,
                                                  input logic [VALUE_W-1:0] above,
                                                  input logic [VALUE_W-1:0] below);
    logic [VALUE_W:0] sum;
    sum = {1'b0, above} + {1'b0, below};
    gap_fill = (centre != '0) ? centre : sum[VALUE_W:1];
  endfunction

  // (a + 2b + c) / 4, truncated
  function automatic logic [VALUE_W-1:0] smooth3(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b,
                                                 input logic [VALUE_W-1:0] c);
    logic [VALUE_W+1:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    smooth3 = sum[VALUE_W+1:2];
  endfunction

  // configuration registers
  logic [8:0]         rows_in_use;
  logic [8:0]         cols_in_use;
  logic signed [23:0] first_row_center;
  logic [15:0]        row_bin_width;

  // window and tracker state
  logic [VALUE_W-1:0] orig0, orig1, fill0, fill1;
  logic [VALUE_W-1:0] orig0_next, orig1_next, fill0_next, fill1_next;
  logic [ROW_W-1:0]   row_count, row_count_next;
  logic [COL_W-1:0]   col_count, col_count_next;
  logic [VALUE_W-1:0] best_value, best_value_next;
  logic [ROW_W-1:0]   best_row, best_row_next;
  logic               best_found, best_found_next;

  // pending stage between the window logic and the queue
  logic [1:0]         p_cnt, p_cnt_next;
  res_item_t          p_item [BURST];
  res_item_t          p_item_next [BURST];
  logic [ROW_W-1:0]   p_best_row, p_best_row_next;
  logic               p_found, p_found_next;

  // output queue
  res_item_t          fifo_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  res_item_t          push_item [BURST];
  res_item_t          head;
  logic               pop;

  // combinational helpers
  logic               accept;
  logic [RCMP_W-1:0]  rows_ext, rows_eff;
  logic [CCMP_W-1:0]  cols_ext, cols_eff;
  logic               edge_col, is_last;
  logic [VALUE_W-1:0] f_prev, f_last, s0, s1;
  logic [ROW_W-1:0]   r0, r1;

  // position math
  logic [PROD_W-1:0]         prod;
  logic signed [SUM_W-1:0]   pos_sum, pos_biased;
  logic signed [SUM_W-9:0]   pos_q;
  logic [POS_W-1:0]          pos_word;

  // ------------------------------------------------------------------
  // configuration port, always ready
  // ------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use      <= RESET_ROWS_IN_USE;
      cols_in_use      <= RESET_COLS_IN_USE;
      first_row_center <= RESET_FIRST_ROW_CENTER;
      row_bin_width    <= RESET_ROW_BIN_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ROWS_IN_USE:      rows_in_use      <= cfg_data[8:0];
        CFG_COLS_IN_USE:      cols_in_use      <= cfg_data[8:0];
        CFG_FIRST_ROW_CENTER: first_row_center <= $signed(cfg_data[23:0]);
        CFG_ROW_BIN_WIDTH:    row_bin_width    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // window, gap fill, smoothing and peak tracking for one bin
  // ------------------------------------------------------------------
  // room for a full column-end burst even if nothing drains
  assign bin_ready = (CNT_W'(count) + CNT_W'(p_cnt)) <= CNT_W'(DEPTH - BURST);
  assign accept    = bin_valid && bin_ready;

  always_comb begin
    // clamp the geometry registers to what the storage supports
    rows_ext = RCMP_W'(rows_in_use);
    if (rows_ext < RCMP_W'(3)) begin
      rows_eff = RCMP_W'(3);
    end else if (rows_ext > RCMP_W'(MAX_ROWS)) begin
      rows_eff = RCMP_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    cols_ext = CCMP_W'(cols_in_use);
    if (cols_ext < CCMP_W'(1)) begin
      cols_eff = CCMP_W'(1);
    end else if (cols_ext > CCMP_W'(MAX_COLS)) begin
      cols_eff = CCMP_W'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end

    edge_col = (col_count == '0) || (CCMP_W'(col_count) >= cols_eff - CCMP_W'(1));
    is_last  = RCMP_W'(row_count) >= rows_eff - RCMP_W'(1);

    f_prev = gap_fill(orig1, orig0, bin_value);
    f_last = gap_fill(bin_value, orig1, '0);
    r0     = row_count - ROW_W'(2);
    r1     = row_count - ROW_W'(1);
    s0     = ((row_count == ROW_W'(2)) || edge_col) ? fill1 : smooth3(fill0, fill1, f_prev);
    s1     = edge_col ? f_prev : smooth3(fill1, f_prev, f_last);

    orig0_next      = orig0;
    orig1_next      = orig1;
    fill0_next      = fill0;
    fill1_next      = fill1;
    row_count_next  = row_count;
    col_count_next  = col_count;
    best_value_next = best_value;
    best_row_next   = best_row;
    best_found_next = best_found;
    p_cnt_next      = 2'd0;
    p_best_row_next = best_row;
    p_found_next    = best_found;
    for (int k = 0; k < BURST; k++) begin
      p_item_next[k] = '0;
    end

    if (accept) begin
      if (row_count == '0) begin
        // first bin of a column: prime the window, restart the tracker
        orig0_next      = '0;
        orig1_next      = bin_value;
        fill0_next      = '0;
        fill1_next      = '0;
        best_value_next = '0;
        best_row_next   = '0;
        best_found_next = 1'b0;
        row_count_next  = ROW_W'(1);
      end else begin
        if (row_count >= ROW_W'(2)) begin
          p_item_next[0].col      = IDX_W'(col_count);
          p_item_next[0].row      = IDX_W'(r0);
          p_item_next[0].filled   = fill1;
          p_item_next[0].smoothed = s0;
          p_cnt_next              = 2'd1;
          if (s0 > best_value_next) begin
            best_value_next = s0;
            best_row_next   = r0;
            best_found_next = 1'b1;
          end
        end
        fill0_next = fill1;
        fill1_next = f_prev;
        orig0_next = orig1;
        orig1_next = bin_value;

        if (is_last) begin
          // flush the last two rows of the column
          p_item_next[1].col      = IDX_W'(col_count);
          p_item_next[1].row      = IDX_W'(r1);
          p_item_next[1].filled   = f_prev;
          p_item_next[1].smoothed = s1;
          if (s1 > best_value_next) begin
            best_value_next = s1;
            best_row_next   = r1;
            best_found_next = 1'b1;
          end
          if (f_last > best_value_next) begin
            best_value_next = f_last;
            best_row_next   = row_count;
            best_found_next = 1'b1;
          end
          p_item_next[2].col      = IDX_W'(col_count);
          p_item_next[2].row      = IDX_W'(row_count);
          p_item_next[2].filled   = f_last;
          p_item_next[2].smoothed = f_last;
          p_item_next[2].done     = 1'b1;
          p_item_next[2].found    = best_found_next;
          p_item_next[2].peak_row = best_found_next ? IDX_W'(best_row_next) : '0;
          p_cnt_next              = 2'd3;
          row_count_next          = '0;
          col_count_next          = (CCMP_W'(col_count) >= cols_eff - CCMP_W'(1)) ?
                                    '0 : col_count + COL_W'(1);
        end else begin
          row_count_next = row_count + ROW_W'(1);
        end
        p_best_row_next = best_row_next;
        p_found_next    = best_found_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orig0      <= '0;
      orig1      <= '0;
      fill0      <= '0;
      fill1      <= '0;
      row_count  <= '0;
      col_count  <= '0;
      best_value <= '0;
      best_row   <= '0;
      best_found <= 1'b0;
      p_cnt      <= 2'd0;
    end else begin
      orig0      <= orig0_next;
      orig1      <= orig1_next;
      fill0      <= fill0_next;
      fill1      <= fill1_next;
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      best_value <= best_value_next;
      best_row   <= best_row_next;
      best_found <= best_found_next;
      p_cnt      <= p_cnt_next;
    end
  end

  // pending payload, no reset needed
  always_ff @(posedge clk) begin
    p_item     <= p_item_next;
    p_best_row <= p_best_row_next;
    p_found    <= p_found_next;
  end

  // ------------------------------------------------------------------
  // peak position: (first_row_center + row * width) / 256, toward zero
  // ------------------------------------------------------------------
  always_comb begin
    prod       = PROD_W'(p_best_row) * PROD_W'(row_bin_width);
    pos_sum    = SUM_W'(first_row_center) + $signed(SUM_W'(prod));
    pos_biased = pos_sum[SUM_W-1] ? pos_sum + SUM_W'(255) : pos_sum;
    pos_q      = $signed(pos_biased[SUM_W-1:8]);
    pos_word   = p_found ? POS_W'(pos_q) : '1;
    for (int k = 0; k < BURST; k++) begin
      push_item[k] = p_item[k];
      if (p_item[k].done) begin
        push_item[k].position = pos_word;
      end
    end
  end

  // ------------------------------------------------------------------
  // output queue: up to three beats in; while res_ready holds, one beat out per cycle
  // ------------------------------------------------------------------
  assign pop  = res_valid && res_ready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int k = 0; k < BURST; k++) begin
      if (2'(k) < p_cnt) begin
        fifo_mem[wr_ptr + PTR_W'(k)] <= push_item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(p_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(p_cnt) - CNT_W'(pop);
    end
  end

  assign res_valid      = count != '0;
  assign out_col        = head.col;
  assign out_row        = head.row;
  assign filled_value   = head.filled;
  assign smoothed_value = head.smoothed;
  assign column_done    = head.done;
  assign peak_found     = head.found;
  assign peak_row       = head.peak_row;
  assign peak_position  = $signed(head.position);

endmodule

/* rtl/core/cgfsp_checker.sv */
module cgfsp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 bin_valid,
  input logic                                 bin_ready,
  input logic                                 res_valid,
  input logic                                 res_ready,
  input logic [cgfsp_pkg::IDX_W-1:0]          out_col,
  input logic [cgfsp_pkg::IDX_W-1:0]          out_row,
  input logic [cgfsp_pkg::VALUE_W-1:0]        smoothed_value,
  input logic                                 column_done,
  input logic                                 peak_found,
  input logic [cgfsp_pkg::IDX_W-1:0]          peak_row,
  input logic signed [cgfsp_pkg::POS_W-1:0]   peak_position
);
  import cgfsp_pkg::*;

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_col) && $stable(out_row)
      && $stable(smoothed_value) && $stable(column_done))
    else $error("result beat changed while stalled");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered right after reset");

  // peak fields stay zero except on the last beat of a column
  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !column_done |-> !peak_found && peak_row == '0 && peak_position == '0)
    else $error("peak fields set outside column end");

  // a column without a peak reports position -1 and row 0
  a_no_peak: assert property (@(posedge clk) disable iff (rst)
    res_valid && column_done && !peak_found |-> peak_position == '1 && peak_row == '0)
    else $error("missing peak not reported as -1");

  // right after reset, no bin is taken while a result is on offer
  a_no_ready_in_reset: assert property (@(posedge clk)
    rst |=> !(bin_valid && bin_ready && res_valid))
    else $error("bin accepted with stale result after reset");

endmodule

bind column_gap_fill_smooth_peak_core cgfsp_checker u_cgfsp_checker (
  .clk            (clk),
  .rst            (rst),
  .bin_valid      (bin_valid),
  .bin_ready      (bin_ready),
  .res_valid      (res_valid),
  .res_ready      (res_ready),
  .out_col        (out_col),
  .out_row        (out_row),
  .smoothed_value (smoothed_value),
  .column_done    (column_done),
  .peak_found     (peak_found),
  .peak_row       (peak_row),
  .peak_position  (peak_position)
);

/* sim/column_gap_fill_smooth_peak_core_test.sv */
`timescale 1ns / 100ps

module column_gap_fill_smooth_peak_core_test;
  import cgfsp_pkg::*;

  localparam int MAX_ROWS = DEFAULT_MAX_ROWS;
  localparam int MAX_COLS = DEFAULT_MAX_COLS;
  // cycles to let pass once nothing is owed: two pipeline stages plus margin
  localparam int DRAIN_CYCLES = 8;
  // limit on a quiet stretch before the watchdog ends the run
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_ROWS_IN_USE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   bin_valid = 1'b0;
  logic                   bin_ready;
  logic [VALUE_W-1:0]     bin_value = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  logic [IDX_W-1:0]       out_col;
  logic [IDX_W-1:0]       out_row;
  logic [VALUE_W-1:0]     filled_value;
  logic [VALUE_W-1:0]     smoothed_value;
  logic                   column_done;
  logic                   peak_found;
  logic [IDX_W-1:0]       peak_row;
  logic signed [POS_W-1:0] peak_position;

  column_gap_fill_smooth_peak_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bin_valid      (bin_valid),
    .bin_ready      (bin_ready),
    .bin_value      (bin_value),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .out_col        (out_col),
    .out_row        (out_row),
    .filled_value   (filled_value),
    .smoothed_value (smoothed_value),
    .column_done    (column_done),
    .peak_found     (peak_found),
    .peak_row       (peak_row),
    .peak_position  (peak_position)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // shadow of the block: register copies, row windows and peak tracker
  // ---------------------------------------------------------------------
  logic [8:0]         rows_reg;
  logic [8:0]         cols_reg;
  logic signed [23:0] center_reg;
  logic [15:0]        width_reg;

  logic [15:0] orig_above, orig_centre;   // raw values of the two rows before
  logic [15:0] fill_above, fill_centre;   // filled values of rows n-3 and n-2
  int unsigned row_cnt, col_cnt;
  logic [15:0] best_val;
  int unsigned best_idx;
  bit          best_seen;

  // result beats worked out from accepted bins, oldest first
  res_item_t out_bins_q[$];
  // bins waiting for the sender
  logic [15:0] bins_to_send[$];

  int unsigned bins_queued = 0;
  int unsigned bins_taken = 0;
  int unsigned cfg_beats = 0;
  int unsigned beats_checked = 0;
  int unsigned columns_closed = 0;
  int unsigned empty_columns = 0;
  int unsigned phase_count = 0;
  int unsigned mismatch_count = 0;
  logic        bin_took = 1'b0;

  function automatic int unsigned clamp_rows(input logic [8:0] rows);
    return (rows < 3) ? 3 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
  endfunction

  // zero bin takes the truncated mean of its raw neighbours
  function automatic logic [15:0] fill_gap(input logic [15:0] centre, above, below);
    logic [16:0] sum;
    sum = {1'b0, above} + {1'b0, below};
    return (centre != 0) ? centre : sum[16:1];
  endfunction

  function automatic logic [15:0] smooth_121(input logic [15:0] a, b, c);
    logic [17:0] sum;
    sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    return sum[17:2];
  endfunction

  // one result beat; peak tracker sees every smoothed value in row order
  task automatic emit_out_bin(input int unsigned row, input logic [15:0] filled,
                              input logic [15:0] smoothed, input bit done);
    res_item_t beat;
    longint    pos;
    if (smoothed > best_val) begin
      best_val  = smoothed;
      best_idx  = row;
      best_seen = 1'b1;
    end
    beat          = '0;
    beat.col      = col_cnt[7:0];
    beat.row      = row[7:0];
    beat.filled   = filled;
    beat.smoothed = smoothed;
    beat.done     = done;
    if (done) begin
      pos = -1;
      if (best_seen) begin
        // signed division truncates toward zero
        pos = (longint'(center_reg) + longint'(best_idx) * longint'(width_reg)) / 256;
        beat.found    = 1'b1;
        beat.peak_row = best_idx[7:0];
      end
      beat.position = pos[17:0];
    end
    out_bins_q = {out_bins_q, beat};
  endtask

  // advance the shadow by one accepted bin
  task automatic fill_smooth_bin(input logic [15:0] v);
    int unsigned rows_eff, cols_eff, n;
    bit          edge_col;
    logic [15:0] f_prev, f_last, s;
    rows_eff = clamp_rows(rows_reg);
    cols_eff = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    n = row_cnt;
    // first and last columns are never smoothed
    edge_col = (col_cnt == 0) || (col_cnt >= cols_eff - 1);
    if (n == 0) begin
      // first bin of a column: start fresh windows and peak search
      orig_above  = '0;
      orig_centre = v;
      fill_above  = '0;
      fill_centre = '0;
      best_val    = '0;
      best_idx    = 0;
      best_seen   = 1'b0;
      row_cnt     = 1;
    end else begin
      f_prev = fill_gap(orig_centre, orig_above, v);
      if (n >= 2) begin
        // row n-2 now has both neighbours; row 0 is an edge row
        s = (n == 2 || edge_col) ? fill_centre
                                 : smooth_121(fill_above, fill_centre, f_prev);
        emit_out_bin(n - 2, fill_centre, s, 1'b0);
      end
      fill_above  = fill_centre;
      fill_centre = f_prev;
      orig_above  = orig_centre;
      orig_centre = v;
      // at or past the last row, even after a lowered rows register
      if (n >= rows_eff - 1) begin
        f_last = fill_gap(orig_centre, orig_above, '0);
        s = edge_col ? fill_centre : smooth_121(fill_above, fill_centre, f_last);
        emit_out_bin(n - 1, fill_centre, s, 1'b0);
        emit_out_bin(n, f_last, f_last, 1'b1);
        row_cnt = 0;
        col_cnt = (col_cnt >= cols_eff - 1) ? 0 : col_cnt + 1;
      end else begin
        row_cnt = n + 1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // monitor: register writes, accepted bins and result beats at the edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    res_item_t want;
    if (rst) begin
      rows_reg    = RESET_ROWS_IN_USE;
      cols_reg    = RESET_COLS_IN_USE;
      center_reg  = RESET_FIRST_ROW_CENTER;
      width_reg   = RESET_ROW_BIN_WIDTH;
      orig_above  = '0;
      orig_centre = '0;
      fill_above  = '0;
      fill_centre = '0;
      row_cnt     = 0;
      col_cnt     = 0;
      best_val    = '0;
      best_idx    = 0;
      best_seen   = 1'b0;
      bin_took   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_beats++;
        case (cfg_index)
          CFG_ROWS_IN_USE:      rows_reg   = cfg_data[8:0];
          CFG_COLS_IN_USE:      cols_reg   = cfg_data[8:0];
          CFG_FIRST_ROW_CENTER: center_reg = cfg_data;
          CFG_ROW_BIN_WIDTH:    width_reg  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (bin_valid && bin_ready) begin
        bins_taken++;
        fill_smooth_bin(bin_value);
      end
      bin_took <= bin_valid && bin_ready;
      if (res_valid && res_ready) begin
        beats_checked++;
        if (out_bins_q.size() == 0) begin
          $display("%0t: result beat col %0d row %0d with nothing expected",
                   $time, out_col, out_row);
          mismatch_count++;
        end else begin
          want = out_bins_q.pop_front();
          if (want.done) begin
            columns_closed++;
            if (!want.found) empty_columns++;
          end
          check_field("out_col", want.col, out_col);
          check_field("out_row", want.row, out_row);
          check_field("filled_value", want.filled, filled_value);
          check_field("smoothed_value", want.smoothed, smoothed_value);
          check_field("column_done", want.done, column_done);
          check_field("peak_found", want.found, peak_found);
          check_field("peak_row", want.peak_row, peak_row);
          check_field("peak_position", want.position, $unsigned(peak_position));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender: bursts of random length, random gaps, long gap-free stretches
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin : sender
    logic        next_valid;
    logic [15:0] next_value;
    next_valid = 1'b0;
    next_value = bin_value;
    if (rst) begin
      next_valid = 1'b0;
    end else if (bin_valid && !bin_took) begin
      // beat still on offer: hold it
      next_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (bins_to_send.size() != 0) begin
      next_valid = 1'b1;
      next_value = bins_to_send.pop_front();
      if (burst_left > 1) begin
        burst_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 90);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left   = $urandom_range(1, 10);
      end
    end
    bin_valid <= next_valid;
    bin_value <= next_value;
  end

  // ---------------------------------------------------------------------
  // receiver: stretches of always ready, sparse, random and full stall
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always @(negedge clk) begin : receiver
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= ($urandom_range(0, 2) == 0);
      2:       res_ready <= ($urandom_range(0, 1) == 1);
      default: res_ready <= 1'b0;
    endcase
  end

  // watchdog: too long with no beat moving on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (bin_valid && bin_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d beats still owed", $time, out_bins_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_bin(input logic [15:0] v);
    bins_to_send = {bins_to_send, v};
    bins_queued++;
  endtask

  // wait until every bin is taken and every beat has come back
  task automatic settle();
    while (bins_taken != bins_queued || out_bins_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [23:0] data);
    int unsigned seen;
    seen = cfg_beats;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (cfg_beats == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [8:0] rows, input logic [8:0] cols,
                            input logic [23:0] center, input logic [15:0] width);
    phase_count++;
    write_reg(CFG_ROWS_IN_USE, {15'd0, rows});
    write_reg(CFG_COLS_IN_USE, {15'd0, cols});
    write_reg(CFG_FIRST_ROW_CENTER, center);
    write_reg(CFG_ROW_BIN_WIDTH, {8'd0, width});
  endtask

  // one column: all zeros, a hump with holes, or a random mix
  task automatic queue_column(input int unsigned len);
    int unsigned kind, top, i, span, step;
    logic [31:0] level;
    kind = $urandom_range(0, 7);
    top  = $urandom_range(0, len - 1);
    step = $urandom_range(1, 200);
    for (i = 0; i < len; i++) begin
      span  = (i > top) ? i - top : top - i;
      level = (len - span) * step;
      if (kind == 0) begin
        queue_bin('0);
      end else if (kind <= 2) begin
        queue_bin(($urandom_range(0, 5) == 0) ? 16'h0000 : level[15:0]);
      end else begin
        case ($urandom_range(0, 7))
          0, 1:    queue_bin('0);
          2:       queue_bin(16'hFFFF);
          3:       queue_bin(16'($urandom_range(1, 15)));
          default: queue_bin(16'($urandom));
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rows_plan [0:6];
    int unsigned cols_plan [0:6];
    int unsigned ncol_plan [0:6];
    int unsigned ph, c, rows_eff;
    logic [23:0] center;
    logic [15:0] width;

    // clamped values, single and two columns; the rows clamp above the
    // storage height is written but no column is run under it
    rows_plan = '{5, 2, 7, 6, 3, 511, 4};
    cols_plan = '{2, 4, 0, 5, 2, 256, 3};
    ncol_plan = '{4, 5, 3, 4, 3, 0, 6};

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset settings: start a column with a hole at the top and a max bin
    queue_bin(16'h0000);
    queue_bin(16'hFFFF);
    queue_bin(16'h0000);
    queue_bin(16'h0001);
    queue_bin(16'h8000);
    settle();

    // rows lowered below the open column, most negative centre, widest bins
    set_config(9'd0, 9'd3, 24'h800000, 16'hFFFF);
    queue_bin(16'h0003);                       // closes the column at row 5
    queue_bin(16'hFFFF);                       // interior column, filled middle
    queue_bin(16'h0000);
    queue_bin(16'hFFFF);
    queue_bin(16'h0005);                       // last column, tie keeps row 0
    queue_bin(16'h0005);
    queue_bin(16'h0005);
    queue_bin(16'h0000);                       // all zero: no peak, position -1
    queue_bin(16'h0000);
    queue_bin(16'h0000);
    settle();

    // one column in use, count wraps back; largest centre, zero width
    set_config(9'd4, 9'd1, 24'h7FFFFF, 16'h0000);
    queue_bin(16'h0001);
    queue_bin(16'h0002);
    queue_bin(16'h0003);
    queue_bin(16'hFFFF);
    queue_bin(16'h0000);
    queue_bin(16'h0007);
    queue_bin(16'h0000);
    queue_bin(16'h0000);

    // random phases; each ends idle before the registers move
    for (ph = 0; ph < 7; ph++) begin
      settle();
      case ($urandom_range(0, 4))
        0:       center = 24'h800000;
        1:       center = 24'h7FFFFF;
        2:       center = 24'h000000;
        default: center = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       width = 16'h0000;
        1:       width = 16'hFFFF;
        2:       width = 16'($urandom_range(1, 1024));
        default: width = 16'($urandom);
      endcase
      set_config(rows_plan[ph][8:0], cols_plan[ph][8:0], center, width);
      rows_eff = clamp_rows(rows_plan[ph][8:0]);
      for (c = 0; c < ncol_plan[ph]; c++) queue_column(rows_eff);
      // leave a column open now and then so the next setting cuts into it
      if (rows_eff < MAX_ROWS && $urandom_range(0, 1) == 1)
        queue_column($urandom_range(1, rows_eff - 1));
    end
    settle();

    if (out_bins_q.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, out_bins_q.size());
      mismatch_count++;
    end
    $display("run covered %0d bins over %0d register settings, %0d result beats checked",
             bins_taken, phase_count + 1, beats_checked);
    $display("%0d columns closed, %0d of them with no peak", columns_closed, empty_columns);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/cgfsp_pkg.sv
rtl/core/column_gap_fill_smooth_peak_core.sv
rtl/core/cgfsp_checker.sv
sim/column_gap_fill_smooth_peak_core_test.sv
